>>> hw/rtl/uhp_pkg.sv
// ----------------------------------------------------------------------------
// uhp_pkg - shared constants of the user/host/port target parser
// Character codes, reset values and limits used by the parser core.
// ----------------------------------------------------------------------------
`default_nettype none

package uhp_pkg;

    // default length limit of one target
    localparam int MAX_LEN_DEF = 255;

    // widths of the fixed payload fields
    localparam int CH_W   = 8;
    localparam int OFS_W  = 8;
    localparam int PORT_W = 16;
    localparam int ACC_W  = 17;

    // port register reset value and accumulator saturation point
    localparam logic [PORT_W-1:0] DEFAULT_PORT_RST = 16'd22;
    localparam logic [ACC_W-1:0]  PORT_SAT         = 17'd65536;
    localparam logic [ACC_W-1:0]  PORT_MAX         = 17'd65535;

    // characters with a meaning to the parser
    localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT      = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF      = 8'h0C;
    localparam logic [CH_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CH_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [CH_W-1:0] CH_AT      = 8'h40;
    localparam logic [CH_W-1:0] CH_UC_A    = 8'h41;
    localparam logic [CH_W-1:0] CH_UC_F    = 8'h46;
    localparam logic [CH_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [CH_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [CH_W-1:0] CH_LC_A    = 8'h61;
    localparam logic [CH_W-1:0] CH_LC_F    = 8'h66;

    // decimal digit test
    function automatic logic is_digit(input logic [CH_W-1:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // hex digit test
    function automatic logic is_hex(input logic [CH_W-1:0] c);
        is_hex = is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_F))
               || ((c >= CH_UC_A) && (c <= CH_UC_F));
    endfunction

    // whitespace or zero byte
    function automatic logic is_blank(input logic [CH_W-1:0] c);
        is_blank = (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR)
                 || (c == CH_LF) || (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/user_host_port_target_parser_core.sv
// ----------------------------------------------------------------------------
// user_host_port_target_parser_core - streaming [user@]host[:port] checker
// Takes the target one byte per beat and gives one verdict beat after the
// byte marked last, with user and host positions and the port number.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  input    | i_in_valid / o_in_stall      | i_ch, i_last
//  output   | o_out_valid / i_out_stall    | o_valid_res .. o_port_number
//  config   | i_cfg_wr_en                  | i_cfg_wr_data (default port)
//
//  One byte per cycle unless o_in_stall is set. A byte is held in the input
//  register, then the parse state and, for a last byte, the result register
//  are updated from it; the verdict is then held in the result register.
//  A stalled output only holds back a last byte; other bytes keep flowing.
//  Reset (synchronous, active low) clears the parse state and sets the
//  default port to 22.
//
`default_nettype none

module user_host_port_target_parser_core #(
    parameter int MAX_LEN = uhp_pkg::MAX_LEN_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [uhp_pkg::PORT_W-1:0] i_cfg_wr_data,
    // input byte channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [uhp_pkg::CH_W-1:0]   i_ch,
    input  wire logic                       i_last,
    // verdict channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_valid_res,
    output logic                            o_user_given,
    output logic [uhp_pkg::OFS_W-1:0]       o_user_length,
    output logic [uhp_pkg::OFS_W-1:0]       o_host_start,
    output logic [uhp_pkg::OFS_W-1:0]       o_host_length,
    output logic [uhp_pkg::PORT_W-1:0]      o_port_number
);

    import uhp_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        PH_START,
        PH_PLAIN,
        PH_BRACKET,
        PH_AFTER,
        PH_PORT
    } t_phase;

    // colon flags of a bracketed host
    typedef struct packed {
        logic first;
        logic second;
        logic prev;
        logic latest;
    } t_edge;

    // default port register
    logic [PORT_W-1:0] r_default_port;

    // input register
    logic            r_in_valid;
    logic [CH_W-1:0] r_ch;
    logic            r_last;

    // parse state
    logic [POS_W-1:0] r_byte_pos, n_byte_pos;
    logic             r_fatal, n_fatal;
    logic             r_at_seen, n_at_seen;
    logic [OFS_W-1:0] r_at_ofs, n_at_ofs;
    t_phase           r_phase, n_phase;
    logic             r_host_err, n_host_err;
    logic             r_colon_seen, n_colon_seen;
    t_edge            r_edge, n_edge;
    logic [OFS_W-1:0] r_host_start, n_host_start;
    logic [POS_W-1:0] r_host_len, n_host_len;
    logic [ACC_W-1:0] r_port_acc, n_port_acc;
    logic             r_port_dig, n_port_dig;

    // result register
    logic              r_out_valid;
    logic              r_res_valid, n_res_valid;
    logic              r_res_user, n_res_user;
    logic [OFS_W-1:0]  r_res_ulen, n_res_ulen;
    logic [OFS_W-1:0]  r_res_hstart, n_res_hstart;
    logic [OFS_W-1:0]  r_res_hlen, n_res_hlen;
    logic [PORT_W-1:0] r_res_port, n_res_port;

    logic           adv;
    logic           colon;
    logic [20:0]    acc_x10;
    t_phase         ph;
    logic           ok;
    logic [PORT_W-1:0] port_sel;

    // byte in the input register moves on unless it is a last byte facing a full output
    assign adv        = r_in_valid && (!r_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign colon      = (r_ch == CH_COLON);
    assign acc_x10    = (21'(r_port_acc) << 3) + (21'(r_port_acc) << 1)
                      + 21'(r_ch - CH_ZERO);

    // per-byte state update
    always_comb begin
        n_byte_pos   = r_byte_pos;
        n_fatal      = r_fatal;
        n_at_seen    = r_at_seen;
        n_at_ofs     = r_at_ofs;
        n_phase      = r_phase;
        n_host_err   = r_host_err;
        n_colon_seen = r_colon_seen;
        n_edge       = r_edge;
        n_host_start = r_host_start;
        n_host_len   = r_host_len;
        n_port_acc   = r_port_acc;
        n_port_dig   = r_port_dig;
        ph           = r_phase;
        if (r_byte_pos >= POS_W'(MAX_LEN)) begin
            n_fatal = 1'b1;
        end else begin
            n_byte_pos = r_byte_pos + POS_W'(1);
            if (is_blank(r_ch)) begin
                n_fatal = 1'b1;
            end else if (r_ch == CH_AT) begin
                if (r_at_seen || (r_byte_pos == '0)) begin
                    n_fatal = 1'b1;
                end else begin
                    // user ends here, host checks start over
                    n_at_seen    = 1'b1;
                    n_at_ofs     = OFS_W'(r_byte_pos);
                    n_phase      = PH_START;
                    n_host_err   = 1'b0;
                    n_colon_seen = 1'b0;
                    n_edge       = '0;
                    n_host_start = '0;
                    n_host_len   = '0;
                    n_port_acc   = '0;
                    n_port_dig   = 1'b0;
                end
            end else begin
                // first host byte picks the host form
                if (r_phase == PH_START) begin
                    if (r_ch == CH_LBRACK) begin
                        ph           = PH_START;
                        n_phase      = PH_BRACKET;
                        n_host_start = OFS_W'(r_byte_pos + POS_W'(1));
                    end else begin
                        ph           = PH_PLAIN;
                        n_phase      = PH_PLAIN;
                        n_host_start = OFS_W'(r_byte_pos);
                    end
                end
                case (ph)
                    PH_START: begin
                        n_phase = PH_BRACKET;
                    end
                    PH_PLAIN: begin
                        if (colon) begin
                            if (r_host_len == '0) begin
                                n_host_err = 1'b1;
                            end
                            n_phase = PH_PORT;
                        end else begin
                            n_host_len = r_host_len + POS_W'(1);
                        end
                    end
                    PH_BRACKET: begin
                        if (r_ch == CH_RBRACK) begin
                            if (r_host_len == '0) begin
                                n_host_err = 1'b1;
                            end else if (!r_colon_seen
                                         || (r_edge.first && !r_edge.second)
                                         || (r_edge.latest && !r_edge.prev)) begin
                                n_host_err = 1'b1;
                            end
                            n_phase = PH_AFTER;
                        end else begin
                            if (!is_hex(r_ch) && !colon && (r_ch != CH_DOT)
                                && (r_ch != CH_PERCENT)) begin
                                n_host_err = 1'b1;
                            end
                            if (colon) begin
                                n_colon_seen = 1'b1;
                            end
                            n_edge.first  = r_edge.first || (colon && (r_host_len == '0));
                            n_edge.second = r_edge.second
                                          || (colon && (r_host_len == POS_W'(1)));
                            n_edge.prev   = r_edge.latest;
                            n_edge.latest = colon;
                            n_host_len    = r_host_len + POS_W'(1);
                        end
                    end
                    PH_AFTER: begin
                        if (colon) begin
                            n_phase = PH_PORT;
                        end else begin
                            n_host_err = 1'b1;
                        end
                    end
                    PH_PORT: begin
                        if (is_digit(r_ch)) begin
                            n_port_acc = (acc_x10 > 21'(PORT_SAT)) ? PORT_SAT
                                                                    : ACC_W'(acc_x10);
                            n_port_dig = 1'b1;
                        end else begin
                            n_host_err = 1'b1;
                        end
                    end
                    default: begin
                        n_host_err = 1'b1;
                    end
                endcase
            end
        end
    end

    // verdict from the state after the last byte
    always_comb begin
        ok       = !n_fatal && !n_host_err;
        port_sel = '0;
        case (n_phase)
            PH_PLAIN, PH_AFTER: begin
                port_sel = r_default_port;
            end
            PH_PORT: begin
                if (!n_port_dig || (n_port_acc == '0) || (n_port_acc > PORT_MAX)) begin
                    ok = 1'b0;
                end else begin
                    port_sel = PORT_W'(n_port_acc);
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        n_res_valid  = ok;
        n_res_user   = ok && n_at_seen;
        n_res_ulen   = (ok && n_at_seen) ? n_at_ofs : '0;
        n_res_hstart = ok ? n_host_start : '0;
        n_res_hlen   = ok ? OFS_W'(n_host_len) : '0;
        n_res_port   = ok ? port_sel : '0;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_port <= DEFAULT_PORT_RST;
        end else if (i_cfg_wr_en) begin
            r_default_port <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    // parse state, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_last)) begin
            r_byte_pos   <= '0;
            r_fatal      <= 1'b0;
            r_at_seen    <= 1'b0;
            r_at_ofs     <= '0;
            r_phase      <= PH_START;
            r_host_err   <= 1'b0;
            r_colon_seen <= 1'b0;
            r_edge       <= '0;
            r_host_start <= '0;
            r_host_len   <= '0;
            r_port_acc   <= '0;
            r_port_dig   <= 1'b0;
        end else if (adv) begin
            r_byte_pos   <= n_byte_pos;
            r_fatal      <= n_fatal;
            r_at_seen    <= n_at_seen;
            r_at_ofs     <= n_at_ofs;
            r_phase      <= n_phase;
            r_host_err   <= n_host_err;
            r_colon_seen <= n_colon_seen;
            r_edge       <= n_edge;
            r_host_start <= n_host_start;
            r_host_len   <= n_host_len;
            r_port_acc   <= n_port_acc;
            r_port_dig   <= n_port_dig;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_last) begin
            r_res_valid  <= n_res_valid;
            r_res_user   <= n_res_user;
            r_res_ulen   <= n_res_ulen;
            r_res_hstart <= n_res_hstart;
            r_res_hlen   <= n_res_hlen;
            r_res_port   <= n_res_port;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_valid_res   = r_res_valid;
    assign o_user_given  = r_res_user;
    assign o_user_length = r_res_ulen;
    assign o_host_start  = r_res_hstart;
    assign o_host_length = r_res_hlen;
    assign o_port_number = r_res_port;

    // checks
    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_last && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked last byte");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_pos <= POS_W'(MAX_LEN))
        else $error("byte position beyond length limit");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |->
            (!o_user_given && (o_port_number == '0) && (o_host_length == '0)))
        else $error("failed verdict carries nonzero fields");

    a_pass_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |-> (o_port_number != '0 || r_default_port == '0))
        else $error("passed verdict with zero parsed port");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_last) |=> ((r_byte_pos == '0) && (r_phase == PH_START)))
        else $error("parse state not cleared after verdict");

endmodule

`default_nettype wire
